FILE: design/tscc_pkg.sv
package tscc_pkg;

    localparam int PKT_W  = 32;
    localparam int SID_W  = 13;
    localparam int SYNC_W = 8;
    localparam int FC_W   = 2;
    localparam int CC_W   = 4;
    localparam int CNT_W  = 32;
    localparam int LAST_W = CC_W + 1;

    localparam int STREAM_SPACE = 1 << SID_W;

    localparam logic [SID_W-1:0]  NULL_STREAM = '1;
    localparam logic [SYNC_W-1:0] SYNC_MARK   = 8'h47;
    localparam logic [LAST_W-1:0] NEVER_SEEN  = LAST_W'(16);
    localparam logic [CNT_W-1:0]  CNT_MAX     = '1;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 168;

    // input tdata, listed from the top bit down
    typedef struct packed {
        logic [4:0]        pad;
        logic [CC_W-1:0]   cont_count;
        logic [FC_W-1:0]   field_control;
        logic [SYNC_W-1:0] sync_value;
        logic [SID_W-1:0]  stream_id;
        logic [PKT_W-1:0]  packet_number;
    } in_item_t;

    // output tdata, listed from the top bit down
    typedef struct packed {
        logic              pad;
        logic [CNT_W-1:0]  all_error_total;
        logic [CNT_W-1:0]  sync_error_total;
        logic [CNT_W-1:0]  packets_seen;
        logic [CNT_W-1:0]  stream_first_error;
        logic [CNT_W-1:0]  stream_error_count;
        logic [CC_W-1:0]   expected_count;
        logic              count_error;
        logic              sync_error;
        logic              reported;
    } out_item_t;

    // per-stream table entry
    typedef struct packed {
        logic [LAST_W-1:0] last_count;
        logic [CNT_W-1:0]  error_count;
        logic [CNT_W-1:0]  first_error;
    } entry_t;

    localparam entry_t CLEAR_ENTRY = '{last_count: NEVER_SEEN, error_count: '0,
                                      first_error: '0};

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

FILE: design/ts_continuity_checker.sv
// a result is registered in stage 1, then in the output register, after its transaction is accepted
// throughput: one packet header per cycle while the output is not stalled,
//   including repeats of the same stream, via write-back forwarding on the table
// reset: all counters clear at once; the 8192-entry stream table is then swept,
//   one entry per cycle, with s_axis_tready low
module ts_continuity_checker
    import tscc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // packet_number, stream_id, sync_value, field_control, cont_count
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // discontinuity_flag
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // reported, sync_error, count_error, expected_count, stream_error_count,
    // stream_first_error, packets_seen, sync_error_total, all_error_total
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);

    entry_t mem [STREAM_SPACE];

    in_item_t         in_item;
    logic             in_accept;
    logic [PKT_W-1:0] in_pkt_inc;

    logic             summarize_reg;
    logic             clr_busy_reg;
    logic [SID_W-1:0] clr_addr_reg;

    logic             s1_valid_reg;
    in_item_t         s1_item_reg;
    logic             s1_disc_reg;
    logic [PKT_W-1:0] s1_pkt_inc_reg;
    logic             fwd_hit_reg;
    entry_t           fwd_data_reg;
    entry_t           rdata_reg;
    logic             s1_adv;

    logic             out_valid_reg;
    out_item_t        out_item_reg;
    out_item_t        out_next;

    logic [CNT_W-1:0] scanned_reg, scanned_next;
    logic [CNT_W-1:0] sync_total_reg, sync_total_next;
    logic [CNT_W-1:0] count_total_reg, count_total_next;
    logic [CNT_W:0]   sum_reg, sum_next;

    logic             mem_we;
    logic [SID_W-1:0] mem_wa;
    entry_t           mem_wd;

    entry_t           cur;
    entry_t           upd_entry;
    logic             sync_err, check, cnt_err, upd;
    logic             sync_inc, cnt_inc;
    logic [CC_W-1:0]  expect_cc;

    assign in_item       = in_item_t'(s_axis_tdata);
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_pkt_inc    = sat_inc(in_item.packet_number);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_item_reg;

    // stage 1: check and update
    always_comb
    begin
        cur       = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        sync_err  = s1_item_reg.sync_value != SYNC_MARK;
        check     = (s1_item_reg.stream_id != NULL_STREAM) && (cur.last_count < NEVER_SEEN)
                    && (s1_item_reg.field_control != '0) && !s1_disc_reg;
        expect_cc = s1_item_reg.field_control[0] ? cur.last_count[CC_W-1:0] + CC_W'(1)
                                                 : cur.last_count[CC_W-1:0];
        cnt_err   = check && (s1_item_reg.cont_count != expect_cc);
        upd       = cnt_err && summarize_reg;

        upd_entry = cur;
        if (upd)
        begin
            upd_entry.error_count = sat_inc(cur.error_count);
            if (cur.error_count == '0)
            begin
                upd_entry.first_error = s1_item_reg.packet_number;
            end
        end
        if (s1_item_reg.field_control != '0)
        begin
            upd_entry.last_count = {1'b0, s1_item_reg.cont_count};
        end

        sync_inc = summarize_reg && sync_err && (sync_total_reg != CNT_MAX);
        cnt_inc  = upd && (count_total_reg != CNT_MAX);
        sync_total_next  = sync_total_reg + CNT_W'(sync_inc);
        count_total_next = count_total_reg + CNT_W'(cnt_inc);
        sum_next = sum_reg + (CNT_W+1)'(sync_inc) + (CNT_W+1)'(cnt_inc);
        scanned_next = (summarize_reg && (s1_pkt_inc_reg > scanned_reg)) ? s1_pkt_inc_reg
                                                                         : scanned_reg;

        out_next                    = '0;
        out_next.reported           = sync_err || cnt_err;
        out_next.sync_error         = sync_err;
        out_next.count_error        = cnt_err;
        out_next.expected_count     = cnt_err ? expect_cc : '0;
        out_next.stream_error_count = upd_entry.error_count;
        out_next.stream_first_error = upd_entry.first_error;
        out_next.packets_seen       = scanned_next;
        out_next.sync_error_total   = sync_total_next;
        out_next.all_error_total    = sum_next[CNT_W] ? CNT_MAX : sum_next[CNT_W-1:0];
    end

    // write port: clearing sweep, then write-back
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = CLEAR_ENTRY;
        end
        else
        begin
            mem_we = s1_adv;
            mem_wa = s1_item_reg.stream_id;
            mem_wd = upd_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (in_accept)
        begin
            rdata_reg <= mem[in_item.stream_id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg    <= in_item;
            s1_disc_reg    <= s_axis_tuser[0];
            s1_pkt_inc_reg <= in_pkt_inc;
            // same-entry write at the read edge
            fwd_hit_reg    <= mem_we && (mem_wa == in_item.stream_id);
            fwd_data_reg   <= mem_wd;
        end
        if (s1_adv)
        begin
            out_item_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summarize_reg   <= 1'b1;
            clr_busy_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            scanned_reg     <= '0;
            sync_total_reg  <= '0;
            count_total_reg <= '0;
            sum_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                summarize_reg <= cfg_data;
            end
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + SID_W'(1);
                if (clr_addr_reg == '1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg   <= 1'b1;
                scanned_reg     <= scanned_next;
                sync_total_reg  <= sync_total_next;
                count_total_reg <= count_total_next;
                sum_reg         <= sum_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: design/tscc_checker.sv
module tscc_checker
    import tscc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    out_item_t res;

    assign res = out_item_t'(m_axis_tdata);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    a_reported: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> res.reported == (res.sync_error || res.count_error))
        else $error("reported differs from sync_error or count_error");

    a_expected_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !res.count_error |-> res.expected_count == '0)
        else $error("expected_count nonzero without count error");

    a_total_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> res.all_error_total >= res.sync_error_total)
        else $error("all_error_total below sync_error_total");

endmodule

bind ts_continuity_checker tscc_checker u_tscc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb
    import tscc_pkg::*;
();

    localparam int RUN_LIMIT     = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BLOCK  = 500;
    localparam int PRESSURE_ITEMS = 60;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // packet_number, stream_id, sync_value, field_control, cont_count
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // discontinuity_flag
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // reported, sync_error, count_error, expected_count, stream_error_count,
    // stream_first_error, packets_seen, sync_error_total, all_error_total
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data = 1'b0;

    ts_continuity_checker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [LAST_W-1:0] last_seen [STREAM_SPACE];
    logic [CNT_W-1:0]  stream_errors [STREAM_SPACE];
    logic [CNT_W-1:0]  stream_first [STREAM_SPACE];
    logic [CNT_W-1:0]  packets_high;
    logic [CNT_W-1:0]  sync_total;
    logic [CNT_W-1:0]  count_total;
    logic              summarize_on;

    // stimulus-side copy of the counters, used to build well-formed runs
    logic [LAST_W-1:0] gen_last [STREAM_SPACE];
    logic [SID_W-1:0]  stream_pool [8];
    logic [PKT_W-1:0]  next_packet = '0;

    out_item_t expected_reports [$];
    int        mismatches = 0;
    int        cycle_count = 0;

    bit sender_quiet = 1'b0;
    bit receiver_quiet = 1'b0;
    bit hold_request = 1'b0;
    int stall_left = 0;

    function automatic logic [CNT_W-1:0] bump32(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic out_item_t predict_report(input in_item_t h, input bit disc);
        out_item_t        r;
        logic [LAST_W-1:0] prev;
        logic [CC_W-1:0]  want;
        logic [CNT_W:0]   sum;
        r = '0;
        if (summarize_on && bump32(h.packet_number) > packets_high)
            packets_high = bump32(h.packet_number);
        if (h.sync_value != SYNC_MARK)
        begin
            r.sync_error = 1'b1;
            if (summarize_on)
                sync_total = bump32(sync_total);
        end
        prev = last_seen[h.stream_id];
        if (h.stream_id != NULL_STREAM && prev != NEVER_SEEN &&
            h.field_control != '0 && !disc)
        begin
            want = h.field_control[0] ? prev[CC_W-1:0] + CC_W'(1) : prev[CC_W-1:0];
            if (h.cont_count != want)
            begin
                r.count_error = 1'b1;
                r.expected_count = want;
                if (summarize_on)
                begin
                    count_total = bump32(count_total);
                    if (stream_errors[h.stream_id] == '0)
                        stream_first[h.stream_id] = h.packet_number;
                    stream_errors[h.stream_id] = bump32(stream_errors[h.stream_id]);
                end
            end
        end
        if (h.field_control != '0)
            last_seen[h.stream_id] = {1'b0, h.cont_count};
        r.reported = r.sync_error | r.count_error;
        r.stream_error_count = stream_errors[h.stream_id];
        r.stream_first_error = stream_first[h.stream_id];
        r.packets_seen = packets_high;
        r.sync_error_total = sync_total;
        sum = {1'b0, sync_total} + {1'b0, count_total};
        r.all_error_total = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        return r;
    endfunction

    function automatic in_item_t make_header(input logic [PKT_W-1:0] pkt,
                                             input logic [SID_W-1:0] sid,
                                             input logic [SYNC_W-1:0] sync,
                                             input logic [FC_W-1:0] fc,
                                             input logic [CC_W-1:0] cc);
        in_item_t h;
        h = '0;
        h.packet_number = pkt;
        h.stream_id = sid;
        h.sync_value = sync;
        h.field_control = fc;
        h.cont_count = cc;
        return h;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (sender_quiet || r < 9)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input and config transactions feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            summarize_on = cfg_data;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_reports.push_back(predict_report(in_item_t'(s_axis_tdata),
                                                      s_axis_tuser[0]));
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = out_item_t'(m_axis_tdata);
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none actual %0h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("reported", 32'(want.reported), 32'(got.reported));
                check_field("sync_error", 32'(want.sync_error), 32'(got.sync_error));
                check_field("count_error", 32'(want.count_error), 32'(got.count_error));
                check_field("expected_count", 32'(want.expected_count),
                            32'(got.expected_count));
                check_field("stream_error_count", want.stream_error_count,
                            got.stream_error_count);
                check_field("stream_first_error", want.stream_first_error,
                            got.stream_first_error);
                check_field("packets_seen", want.packets_seen, got.packets_seen);
                check_field("sync_error_total", want.sync_error_total,
                            got.sync_error_total);
                check_field("all_error_total", want.all_error_total,
                            got.all_error_total);
            end
        end
    end

    // receiver with random stalls and an occasional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !receiver_quiet && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_header(input in_item_t h, input bit disc);
        int gap;
        s_axis_tdata <= h;
        s_axis_tuser <= disc;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (h.field_control != '0)
            gen_last[h.stream_id] = {1'b0, h.cont_count};
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_directed(input logic [SID_W-1:0] sid, input logic [SYNC_W-1:0] sync,
                                 input logic [FC_W-1:0] fc, input logic [CC_W-1:0] cc,
                                 input bit disc);
        send_header(make_header(next_packet, sid, sync, fc, cc), disc);
        next_packet++;
    endtask

    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_summarize(input bit value);
        finish_phase();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_reset();
        for (int i = 0; i < STREAM_SPACE; i++)
        begin
            last_seen[SID_W'(i)] = NEVER_SEEN;
            gen_last[SID_W'(i)] = NEVER_SEEN;
            stream_errors[SID_W'(i)] = '0;
            stream_first[SID_W'(i)] = '0;
        end
        packets_high = '0;
        sync_total = '0;
        count_total = '0;
        summarize_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    endtask

    task automatic test_continuity_rules();
        send_directed(13'd0, SYNC_MARK, 2'd1, 4'd5, 1'b0);
        send_directed(13'd0, SYNC_MARK, 2'd1, 4'd6, 1'b0);
        send_directed(13'd0, SYNC_MARK, 2'd2, 4'd6, 1'b0);
        send_directed(13'd0, SYNC_MARK, 2'd3, 4'd9, 1'b0);
        send_directed(13'd0, SYNC_MARK, 2'd0, 4'd0, 1'b0);
        send_directed(13'd0, SYNC_MARK, 2'd1, 4'd15, 1'b1);
        send_directed(13'd0, SYNC_MARK, 2'd1, 4'd0, 1'b0);
        send_directed(13'd0, SYNC_MARK, 2'd1, 4'd3, 1'b0);
        send_directed(NULL_STREAM, SYNC_MARK, 2'd1, 4'd4, 1'b0);
        send_directed(NULL_STREAM, SYNC_MARK, 2'd1, 4'd9, 1'b0);
        send_directed(13'h1FFE, SYNC_MARK, 2'd3, 4'd15, 1'b0);
        send_directed(13'h1FFE, SYNC_MARK, 2'd3, 4'd0, 1'b0);
        send_directed(13'h1FFE, SYNC_MARK, 2'd2, 4'd4, 1'b0);
        send_directed(13'h0AAA, SYNC_MARK, 2'd0, 4'd7, 1'b0);
        send_directed(13'h0AAA, SYNC_MARK, 2'd1, 4'd2, 1'b0);
        finish_phase();
    endtask

    task automatic test_sync_errors();
        send_directed(13'h1555, 8'h00, 2'd1, 4'd0, 1'b0);
        send_directed(13'h1555, 8'hFF, 2'd1, 4'd1, 1'b0);
        send_directed(13'h1555, 8'h46, 2'd1, 4'd9, 1'b0);
        finish_phase();
    endtask

    task automatic test_summarize_off();
        write_summarize(1'b0);
        send_directed(13'd0, SYNC_MARK, 2'd1, 4'd12, 1'b0);
        send_directed(13'h1555, 8'h12, 2'd1, 4'd0, 1'b0);
        send_directed(13'h0123, SYNC_MARK, 2'd1, 4'd8, 1'b0);
        send_directed(13'h0123, SYNC_MARK, 2'd1, 4'd1, 1'b0);
        write_summarize(1'b1);
        send_directed(13'h0123, SYNC_MARK, 2'd1, 4'd5, 1'b0);
        finish_phase();
    endtask

    task automatic random_header(output in_item_t h, output bit disc);
        logic [SID_W-1:0] sid;
        logic [FC_W-1:0]  fc;
        logic [CC_W-1:0]  cc;
        logic [LAST_W-1:0] prev;
        int r;
        if ($urandom_range(0, 9) == 0)
        begin
            h = make_header($urandom, SID_W'($urandom_range(0, STREAM_SPACE - 1)),
                            SYNC_W'($urandom_range(0, 255)), FC_W'($urandom_range(0, 3)),
                            CC_W'($urandom_range(0, 15)));
            disc = 1'($urandom_range(0, 1));
            return;
        end
        sid = stream_pool[3'($urandom_range(0, 7))];
        r = $urandom_range(0, 99);
        fc = (r < 60) ? 2'd1 : (r < 80) ? 2'd3 : (r < 90) ? 2'd2 : 2'd0;
        prev = gen_last[sid];
        if (prev == NEVER_SEEN || $urandom_range(0, 7) == 0)
            cc = CC_W'($urandom_range(0, 15));
        else
            cc = fc[0] ? prev[CC_W-1:0] + CC_W'(1) : prev[CC_W-1:0];
        h = make_header(next_packet, sid,
                        ($urandom_range(0, 19) == 0) ? SYNC_W'($urandom_range(0, 255))
                                                     : SYNC_MARK,
                        fc, cc);
        disc = ($urandom_range(0, 19) == 0);
        next_packet++;
    endtask

    task automatic run_random(input int count);
        in_item_t h;
        bit       disc;
        for (int i = 0; i < count; i++)
        begin
            random_header(h, disc);
            send_header(h, disc);
        end
        finish_phase();
    endtask

    task automatic test_random_streams();
        stream_pool[0] = '0;
        stream_pool[1] = NULL_STREAM;
        stream_pool[2] = 13'h1FFE;
        for (int i = 3; i < 8; i++)
            stream_pool[3'(i)] = SID_W'($urandom_range(0, STREAM_SPACE - 1));
        run_random(RANDOM_BLOCK);
        write_summarize(1'b0);
        run_random(RANDOM_BLOCK / 2);
        write_summarize(1'b1);
        sender_quiet = 1'b1;
        receiver_quiet = 1'b1;
        run_random(RANDOM_BLOCK / 2);
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        run_random(RANDOM_BLOCK);
    endtask

    task automatic test_output_backpressure();
        in_item_t h;
        bit       disc;
        sender_quiet = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
        begin
            random_header(h, disc);
            send_header(h, disc);
        end
        sender_quiet = 1'b0;
        finish_phase();
        run_random(RANDOM_BLOCK / 2);
    endtask

    task automatic test_packet_saturation();
        send_header(make_header(32'hFFFF_FFFE, 13'h0040, SYNC_MARK, 2'd1, 4'd3), 1'b0);
        send_header(make_header(32'hFFFF_FFFF, 13'h0040, SYNC_MARK, 2'd1, 4'd9), 1'b0);
        send_header(make_header(32'h0000_0001, 13'h0040, 8'hB8, 2'd3, 4'd10), 1'b1);
        finish_phase();
    endtask

    initial
    begin
        apply_reset();
        test_continuity_rules();
        test_sync_errors();
        test_summarize_off();
        test_random_streams();
        test_output_backpressure();
        test_packet_saturation();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/tscc_pkg.sv
design/ts_continuity_checker.sv
design/tscc_checker.sv
test/tb.sv
